### rtl/sirt_pkg.sv
// Shared types and constants for the signed integer to radix text converter.
package sirt_pkg;

  localparam int unsigned SymSlots   = 16;
  localparam int unsigned DigitMax   = 32;
  localparam int unsigned ChunkBits  = 8;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned StepCount  = ValueBits / ChunkBits;

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;

  localparam logic REG_ALPHABET_LOW  = 1'b0;
  localparam logic REG_ALPHABET_HIGH = 1'b1;

  typedef logic [3:0] digit_t;
  typedef logic [4:0] base_len_t;
  typedef logic [5:0] digit_cnt_t;
  typedef logic [$clog2(StepCount)-1:0] step_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

endpackage

### rtl/signed_integer_to_radix_text_core.sv
// Top level of the signed integer to radix text converter.
//
// The input channel (in_valid, in_ready, value) takes one signed 32-bit number.
// The output channel (out_valid, out_ready, symbol, last) gives its text, one
// character per item, most significant digit first, with last high on the
// final character. A negative number starts with a minus byte.
// The digit alphabet sits in two 64-bit registers written through cfg_we,
// cfg_index and cfg_data; an alphabet that is too short, holds a sign byte or
// repeats a symbol gives no characters for the number.
// One shared 8-bit-per-cycle divide unit produces each digit chunk by chunk,
// most significant byte first; once all D digits are divided out, the D
// characters (plus a sign) leave at one per cycle while out_ready stays high.
// in_ready is high only while the converter is idle; a new number is taken
// while the final character still waits in the output register.
// When the receiver stalls, the output register holds its character and the
// converter waits. Reset clears both alphabet registers and all control state.
module signed_integer_to_radix_text_core
  import sirt_pkg::*;
#(
  parameter int unsigned MAX_BASE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  symbol,
  output logic        last
);

  localparam int unsigned Cap = (MAX_BASE < SymSlots) ? MAX_BASE : SymSlots;

  logic [63:0] alphabet_low;
  logic [63:0] alphabet_high;
  logic [7:0]  sym_tab [SymSlots];

  state_t state;
  state_t state_next;

  logic [ValueBits-1:0] div_w;
  digit_t               rem;
  step_t                step;
  base_len_t            len;
  logic                 neg_pend;
  digit_cnt_t           nd;
  digit_t               stack [DigitMax];

  logic [SymSlots-1:0] counted;
  base_len_t           cfg_len;
  logic                base_ok;
  logic                accept;
  logic [ChunkBits-1:0] qbits;
  digit_t               rem_new;
  logic [ValueBits-1:0] quotient;
  logic                 emit_load;
  logic                 emit_sign;
  logic                 emit_done;
  digit_cnt_t           nd_m1;

  always_comb begin
    for (int k = 0; k < SymSlots / 2; k++) begin
      sym_tab[k]                = alphabet_low[8*k +: 8];
      sym_tab[k + SymSlots / 2] = alphabet_high[8*k +: 8];
    end
  end

  always_comb begin
    logic run;
    logic bad;
    run     = 1'b1;
    bad     = 1'b0;
    cfg_len = '0;
    for (int k = 0; k < SymSlots; k++) begin
      run        = run && (k < Cap) && (sym_tab[k] != 8'h00);
      counted[k] = run;
      cfg_len    = cfg_len + base_len_t'(run);
    end
    for (int a = 0; a < SymSlots; a++) begin
      if (counted[a] && (sym_tab[a] == SYM_PLUS || sym_tab[a] == SYM_MINUS)) begin
        bad = 1'b1;
      end
      for (int b = a + 1; b < SymSlots; b++) begin
        if (counted[b] && sym_tab[a] == sym_tab[b]) begin
          bad = 1'b1;
        end
      end
    end
    base_ok = !bad && (cfg_len >= base_len_t'(2));
  end

  always_comb begin
    logic [4:0] t;
    digit_t     r;
    r     = rem;
    qbits = '0;
    for (int i = ChunkBits - 1; i >= 0; i--) begin
      t = {r, div_w[ValueBits - ChunkBits + i]};
      if (t >= len) begin
        t        = t - len;
        qbits[i] = 1'b1;
      end
      r = t[3:0];
    end
    rem_new  = r;
    quotient = {div_w[ValueBits-ChunkBits-1:0], qbits};
  end

  assign nd_m1 = nd - digit_cnt_t'(1);

  always_comb begin
    in_ready  = (state == S_IDLE);
    accept    = in_valid && in_ready;
    emit_load = (state == S_EMIT) && (!out_valid || out_ready);
    emit_sign = emit_load && neg_pend;
    emit_done = emit_load && !neg_pend && (nd == digit_cnt_t'(1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && base_ok) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == step_t'(StepCount - 1) &&
            (quotient == '0 || nd == digit_cnt_t'(DigitMax - 1))) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ALPHABET_LOW) begin
        alphabet_low <= cfg_data;
      end else begin
        alphabet_high <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      neg_pend  <= 1'b0;
      nd        <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && base_ok) begin
        neg_pend <= value[ValueBits-1];
        nd       <= '0;
        step     <= '0;
      end
      if (state == S_DIV) begin
        step <= step + step_t'(1);
        if (step == step_t'(StepCount - 1)) begin
          nd <= nd + digit_cnt_t'(1);
        end
      end
      if (emit_load) begin
        out_valid <= 1'b1;
        if (emit_sign) begin
          neg_pend <= 1'b0;
        end else begin
          nd <= nd_m1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      div_w <= value[ValueBits-1] ? (ValueBits'(0) - ValueBits'(value)) : ValueBits'(value);
      rem   <= '0;
      len   <= cfg_len;
    end else if (state == S_DIV) begin
      if (step == step_t'(StepCount - 1)) begin
        div_w                <= quotient;
        rem                  <= '0;
        stack[nd[4:0]]       <= rem_new;
      end else begin
        div_w <= quotient;
        rem   <= rem_new;
      end
    end
    if (emit_load) begin
      if (emit_sign) begin
        symbol <= SYM_MINUS;
        last   <= 1'b0;
      end else begin
        symbol <= sym_tab[stack[nd_m1[4:0]]];
        last   <= (nd == digit_cnt_t'(1));
      end
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (rst)
    nd <= digit_cnt_t'(DigitMax))
    else $error("digit count beyond the stack depth");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, rem} < len))
    else $error("partial remainder not below the base");

  a_bad_base_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && !base_ok) |=> (state == S_IDLE))
    else $error("invalid alphabet did not drop the item");

  a_sign_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !neg_pend)
    else $error("minus sign still pending when idle");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (nd != '0))
    else $error("emitting with an empty digit stack");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the signed integer to radix text converter.
module testbench
  import sirt_pkg::*;
;

  localparam int unsigned MaxBase = 16;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [31:0] MostNegative = 32'h8000_0000;
  localparam logic [31:0] MostPositive = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } text_char_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [63:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] number;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         symbol;
  logic               last;

  logic [63:0]  digit_set_lo;
  logic [63:0]  digit_set_hi;
  text_char_t   expected_chars[$];
  int unsigned  error_count = 0;
  bit           sender_gaps;
  bit           receiver_gaps;
  int unsigned  receiver_hold_cycles;

  signed_integer_to_radix_text_core #(
    .MAX_BASE(MaxBase)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .symbol(symbol),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [7:0] symbol_slot(input int unsigned k);
    if (k < 8) begin
      return digit_set_lo[8*k +: 8];
    end
    return digit_set_hi[8*(k-8) +: 8];
  endfunction

  // Returns the radix, or zero when the alphabet cannot be used.
  function automatic int unsigned radix_of();
    int unsigned cap;
    int unsigned len;
    cap = (MaxBase < SymSlots) ? MaxBase : SymSlots;
    len = 0;
    while (len < cap && symbol_slot(len) != 8'h00) len++;
    if (len < 2) return 0;
    for (int unsigned a = 0; a < len; a++) begin
      if (symbol_slot(a) == SYM_PLUS || symbol_slot(a) == SYM_MINUS) return 0;
      for (int unsigned b = a + 1; b < len; b++) begin
        if (symbol_slot(b) == symbol_slot(a)) return 0;
      end
    end
    return len;
  endfunction

  function automatic void predict_text(input logic [31:0] raw);
    int unsigned radix;
    logic [31:0] mag;
    logic [7:0]  digits[$];
    radix = radix_of();
    if (radix == 0) return;
    mag = raw[31] ? (32'd0 - raw) : raw;
    if (mag == 0) digits.push_front(symbol_slot(0));
    while (mag != 0) begin
      digits.push_front(symbol_slot(mag % radix));
      mag = mag / radix;
    end
    if (raw[31]) expected_chars.push_back('{symbol: SYM_MINUS, last: 1'b0});
    foreach (digits[i]) begin
      expected_chars.push_back('{symbol: digits[i], last: (i == digits.size() - 1)});
    end
  endfunction

  function automatic logic [127:0] text_alphabet(input string s);
    logic [127:0] packed_set;
    packed_set = '0;
    for (int i = 0; i < s.len() && i < 16; i++) packed_set[8*i +: 8] = s[i];
    return packed_set;
  endfunction

  // Distinct nonzero non-sign symbols, junk after the terminator; spoil adds a fault.
  function automatic logic [127:0] random_alphabet(input bit spoil);
    logic [127:0] packed_set;
    int unsigned  len;
    int unsigned  k;
    int unsigned  src;
    logic [7:0]   candidate;
    bit           clash;
    packed_set = {$urandom, $urandom, $urandom, $urandom};
    len = ($urandom_range(3) == 0) ? 16 : $urandom_range(2, 16);
    for (k = 0; k < len; k++) begin
      do begin
        candidate = 8'($urandom_range(1, 255));
        clash = (candidate == SYM_PLUS || candidate == SYM_MINUS);
        for (int unsigned j = 0; j < k; j++) begin
          if (packed_set[8*j +: 8] == candidate) clash = 1'b1;
        end
      end while (clash);
      packed_set[8*k +: 8] = candidate;
    end
    if (len < 16) packed_set[8*len +: 8] = 8'h00;
    if (spoil) begin
      k = $urandom_range(1, len - 1);
      src = $urandom_range(k - 1);
      case ($urandom_range(2))
        0: packed_set[8*k +: 8] = SYM_PLUS;
        1: packed_set[8*src +: 8] = SYM_MINUS;
        default: packed_set[8*k +: 8] = packed_set[8*src +: 8];
      endcase
    end
    return packed_set;
  endfunction

  function automatic logic [31:0] random_number();
    case ($urandom_range(5))
      0: return $urandom_range(0, 40);
      1: return 32'd0 - $urandom_range(1, 40);
      2: return MostNegative + $urandom_range(0, 2);
      3: return MostPositive - $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("character with none outstanding", 32'(symbol), 32'd0);
      end else begin
        want = expected_chars.pop_front();
        if (symbol !== want.symbol) begin
          report_mismatch("symbol", 32'(symbol), 32'(want.symbol));
        end
        if (last !== want.last) report_mismatch("last flag", 32'(last), 32'(want.last));
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (receiver_hold_cycles) @(negedge clk);
        receiver_hold_cycles = 0;
      end else begin
        out_ready <= !(receiver_gaps && $urandom_range(99) < 22);
      end
    end
  end

  task automatic send_number(input logic [31:0] v);
    @(negedge clk);
    if (sender_gaps && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    number <= v;
    do @(posedge clk); while (!in_ready);
    predict_text(v);
  endtask

  task automatic wait_for_drain(input int unsigned settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_register(input logic index, input logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == REG_ALPHABET_LOW) begin
      digit_set_lo = data;
    end else begin
      digit_set_hi = data;
    end
  endtask

  task automatic set_alphabet(input logic [127:0] packed_set);
    write_register(REG_ALPHABET_LOW, packed_set[63:0]);
    write_register(REG_ALPHABET_HIGH, packed_set[127:64]);
  endtask

  task automatic test_reset_alphabet();
    send_number(32'd0);
    send_number(32'd0 - 32'd5);
    wait_for_drain(SettleCycles);
  endtask

  task automatic test_decimal();
    set_alphabet(text_alphabet("0123456789"));
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hFFFF_FFFF);
    send_number(32'd9);
    send_number(32'd10);
    send_number(32'd0 - 32'd10);
    send_number(MostPositive);
    send_number(MostNegative);
    wait_for_drain(SettleCycles);
  endtask

  task automatic test_binary_longest();
    set_alphabet(text_alphabet("01"));
    send_number(MostNegative);
    send_number(MostPositive);
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);
    wait_for_drain(SettleCycles);
  endtask

  task automatic test_full_hex();
    set_alphabet(text_alphabet("0123456789abcdef"));
    send_number(32'd15);
    send_number(32'd0 - 32'd16);
    send_number(MostPositive);
    send_number(MostNegative);
    wait_for_drain(SettleCycles);
  endtask

  task automatic test_invalid_alphabets();
    set_alphabet(text_alphabet("7"));
    send_number(32'd42);
    wait_for_drain(SettleCycles);
    set_alphabet(text_alphabet("01+3"));
    send_number(32'd42);
    wait_for_drain(SettleCycles);
    set_alphabet(text_alphabet("0-"));
    send_number(32'd0 - 32'd42);
    wait_for_drain(SettleCycles);
    set_alphabet(text_alphabet("012342"));
    send_number(MostNegative);
    wait_for_drain(SettleCycles);
    set_alphabet(text_alphabet("0123456789abcde0"));
    send_number(MostPositive);
    wait_for_drain(SettleCycles);
  endtask

  // Sign bytes and repeats after the terminator must not spoil the alphabet.
  task automatic test_trailing_bytes();
    logic [127:0] octal_set;
    octal_set = text_alphabet("01234567");
    set_alphabet({64'h2B2D_3030_2D2B_2D00, octal_set[63:0]});
    send_number(32'd8);
    send_number(MostNegative);
    wait_for_drain(SettleCycles);
  endtask

  task automatic test_receiver_hold();
    set_alphabet(random_alphabet(1'b0));
    receiver_hold_cycles = HoldOffCycles;
    repeat (6) send_number(random_number());
    wait_for_drain(SettleCycles);
  endtask

  task automatic test_sender_pause();
    set_alphabet(random_alphabet(1'b0));
    repeat (4) send_number(random_number());
    wait_for_drain(0);
    repeat (4) send_number(random_number());
    wait_for_drain(SettleCycles);
  endtask

  task automatic test_random_numbers(input int unsigned rounds);
    for (int unsigned r = 0; r < rounds; r++) begin
      sender_gaps = (r != 0);
      receiver_gaps = (r != 0);
      set_alphabet(random_alphabet($urandom_range(7) == 0));
      repeat (18) send_number(random_number());
      wait_for_drain(SettleCycles);
    end
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ALPHABET_LOW;
    cfg_data = '0;
    in_valid = 1'b0;
    number = '0;
    digit_set_lo = '0;
    digit_set_hi = '0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    receiver_hold_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_alphabet();
    test_decimal();
    test_binary_longest();
    test_full_hex();
    test_invalid_alphabets();
    test_trailing_bytes();
    test_receiver_hold();
    test_sender_pause();
    test_random_numbers(7);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
